[rtl/core/lda_pkg.sv]
// lda_pkg: shared widths, register codes and rounding helpers for the
// lens distortion datapath. No dependencies; imported by lens_distortion_apply_top and its testbench.
`default_nettype none

package lda_pkg;

  // Field widths and fixed-point formats
  localparam int COORD_WIDTH = 24;               // Q3.20 coordinates
  localparam int COEFF_WIDTH = 32;               // Q7.24 coefficients
  localparam int FRAC_C      = COORD_WIDTH - 4;  // coordinate fraction bits
  localparam int FRAC_K      = COEFF_WIDTH - 8;  // coefficient fraction bits
  localparam int CFG_IDX_W   = 3;

  // Intermediate widths, sized from the worst-case magnitudes
  localparam int SQ_W  = 2 * COORD_WIDTH - FRAC_C;          // xx, yy, xy
  localparam int R2_W  = SQ_W + 1;                          // r2, 2*xy
  localparam int TS_W  = SQ_W + 2;                          // r2 + 2*xx
  localparam int R4_W  = 2 * R2_W - FRAC_C - 2;             // r2^2
  localparam int R6_W  = R4_W + R2_W - FRAC_C - 2;          // r2^3
  localparam int KR2_W = COEFF_WIDTH + R2_W - FRAC_K - 1;   // k1*r2, p*2xy
  localparam int KT_W  = COEFF_WIDTH + TS_W - FRAC_K - 1;   // p*(r2+2xx)
  localparam int TX_W  = KT_W + 1;                          // tangential sum
  localparam int KR4_W = COEFF_WIDTH + R4_W - FRAC_K - 1;   // k2*r4
  localparam int KR6_W = COEFF_WIDTH + R6_W - FRAC_K - 1;   // k3*r6
  localparam int FAC_W = KR6_W + 1;                         // radial factor
  localparam int MX_W  = COORD_WIDTH + FAC_W - FRAC_C - 1;  // x*fac
  localparam int OX_W  = MX_W + 1;                          // before clamp

  // Operand splits for the wide products (low part is unsigned)
  localparam int R4_LO_W  = R4_W / 2;
  localparam int R4_HI_W  = R4_W - R4_LO_W;
  localparam int R6_LO_W  = R6_W / 2;
  localparam int R6_HI_W  = R6_W - R6_LO_W;
  localparam int FAC_LO_W = FAC_W / 2;
  localparam int FAC_HI_W = FAC_W - FAC_LO_W;

  // Partial product widths
  localparam int R6P_LO_W = R4_LO_W + 1 + R2_W;
  localparam int R6P_HI_W = R4_HI_W + R2_W;
  localparam int K4P_LO_W = COEFF_WIDTH + R4_LO_W + 1;
  localparam int K4P_HI_W = COEFF_WIDTH + R4_HI_W;
  localparam int K6P_LO_W = COEFF_WIDTH + R6_LO_W + 1;
  localparam int K6P_HI_W = COEFF_WIDTH + R6_HI_W;
  localparam int XFP_LO_W = COORD_WIDTH + FAC_LO_W + 1;
  localparam int XFP_HI_W = COORD_WIDTH + FAC_HI_W;

  // Common width for full products before rounding
  localparam int MUL_W = ((COEFF_WIDTH + R6_W) > (COORD_WIDTH + FAC_W)) ?
                         (COEFF_WIDTH + R6_W + 1) : (COORD_WIDTH + FAC_W + 1);

  typedef logic signed [MUL_W-1:0] mul_t;

  localparam mul_t HALF_C = mul_t'(1) <<< (FRAC_C - 1);
  localparam mul_t HALF_K = mul_t'(1) <<< (FRAC_K - 1);

  // Output clamp limits
  localparam logic signed [OX_W-1:0] OUT_MAX = OX_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [OX_W-1:0] OUT_MIN = -OUT_MAX - OX_W'(1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 3'd0,
    REG_K1     = 3'd1,
    REG_K2     = 3'd2,
    REG_K3     = 3'd3,
    REG_P1     = 3'd4,
    REG_P2     = 3'd5
  } cfg_reg_e;

  // Round p / 2^FRAC_C to nearest, ties away from zero
  function automatic mul_t rnd_c(input mul_t p);
    mul_t s;
    s    = '0;
    s[0] = p[MUL_W-1];
    return (p + HALF_C - s) >>> FRAC_C;
  endfunction

  // Round p / 2^FRAC_K to nearest, ties away from zero
  function automatic mul_t rnd_k(input mul_t p);
    mul_t s;
    s    = '0;
    s[0] = p[MUL_W-1];
    return (p + HALF_K - s) >>> FRAC_K;
  endfunction

endpackage

`default_nettype wire

[rtl/core/lens_distortion_apply_top.sv]
// lens_distortion_apply_top: pipelined Brown-Conrady distortion (k1..k3, p1, p2)
// of one Q3.20 point per cycle. Depends on lda_pkg.
//
// Usage:
//   Points enter on point_x_i/point_y_i, taken at each rising edge with start_i
//   high and busy_o low. busy_o stays low: the pipeline takes one point every
//   cycle, back to back.
//   Each result appears on out_x_o/out_y_o/saturated_o for exactly one cycle,
//   marked by result_valid_o, after its point has passed the chain of eleven
//   register stages (squares, r2, r4 and r6 products, the radial factor sum,
//   x*fac, clamp); throughput is one point per cycle.
//   The receiver cannot stall; results are never held back or dropped.
//   Configuration words arrive on cfg_valid_i/cfg_index_i/cfg_data_i and are
//   taken when cfg_ready_o (always high) meets cfg_valid_i. Write them only
//   while no point is in flight. Unknown indexes are ignored.
//   Reset clears the pipeline valid bits and sets every configuration register
//   to zero, so correction starts disabled (points pass through, saturated_o low).
//   Outputs saturate to the coordinate range; saturated_o flags the clamp.
`default_nettype none

module lens_distortion_apply_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // point channel
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [lda_pkg::COORD_WIDTH-1:0] point_x_i,
  input  logic signed [lda_pkg::COORD_WIDTH-1:0] point_y_i,
  // configuration channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [lda_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [lda_pkg::COEFF_WIDTH-1:0]       cfg_data_i,
  // result channel
  output logic                                  result_valid_o,
  output logic signed [lda_pkg::COORD_WIDTH-1:0] out_x_o,
  output logic signed [lda_pkg::COORD_WIDTH-1:0] out_y_o,
  output logic                                  saturated_o
);
  import lda_pkg::*;

  localparam int LAT = 11;
  localparam logic signed [FAC_W-1:0] FAC_ONE = FAC_W'(1) <<< FRAC_C;

  // Configuration registers
  logic                          enable_q;
  logic signed [COEFF_WIDTH-1:0] k1_q, k2_q, k3_q, p1_q, p2_q;

  // Valid bits and carried coordinates / tangential terms
  logic                          v_q  [1:LAT];
  logic signed [COORD_WIDTH-1:0] xp_q [1:10];
  logic signed [COORD_WIDTH-1:0] yp_q [1:10];
  logic signed [TX_W-1:0]        tx_q [4:10];
  logic signed [TX_W-1:0]        ty_q [4:10];

  // Stage 1
  logic signed [SQ_W-1:0]     xx_q, yy_q, xy_q, xx_d, yy_d, xy_d;
  // Stage 2
  logic signed [R2_W-1:0]     r2_q, xy2_q, r2_d, xy2_d;
  logic signed [TS_W-1:0]     sx_q, sy_q, sx_d, sy_d;
  // Stage 3
  logic signed [R2_W-1:0]     r2b_q;
  logic signed [R4_W-1:0]     r4_q, r4_d;
  logic signed [KR2_W-1:0]    kr2_q, ta_q, tc_q, kr2_d, ta_d, tc_d;
  logic signed [KT_W-1:0]     tb_q, td_q, tb_d, td_d;
  // Stage 4
  logic signed [R6P_LO_W-1:0] r6lo_q, r6lo_d;
  logic signed [R6P_HI_W-1:0] r6hi_q, r6hi_d;
  logic signed [K4P_LO_W-1:0] k4lo_q, k4lo_d;
  logic signed [K4P_HI_W-1:0] k4hi_q, k4hi_d;
  logic signed [FAC_W-1:0]    fac1_q, fac1_d;
  logic signed [TX_W-1:0]     tx_d, ty_d;
  // Stage 5
  logic signed [R6_W-1:0]     r6_q, r6_d;
  logic signed [KR4_W-1:0]    kr4_q, kr4_d;
  logic signed [FAC_W-1:0]    fac1b_q;
  // Stage 6
  logic signed [K6P_LO_W-1:0] k6lo_q, k6lo_d;
  logic signed [K6P_HI_W-1:0] k6hi_q, k6hi_d;
  logic signed [FAC_W-1:0]    fac2_q, fac2_d;
  // Stage 7
  logic signed [KR6_W-1:0]    kr6_q, kr6_d;
  logic signed [FAC_W-1:0]    fac2b_q;
  // Stage 8
  logic signed [FAC_W-1:0]    fac_q, fac_d;
  // Stage 9
  logic signed [XFP_LO_W-1:0] mxlo_q, mylo_q, mxlo_d, mylo_d;
  logic signed [XFP_HI_W-1:0] mxhi_q, myhi_q, mxhi_d, myhi_d;
  // Stage 10
  logic signed [MX_W-1:0]     mx_q, my_q, mx_d, my_d;
  // Stage 11 (output)
  logic signed [COORD_WIDTH-1:0] out_x_q, out_y_q, out_x_d, out_y_d;
  logic                          sat_q, sat_d;

  // Operand splits
  logic signed [R4_LO_W:0]    r4_lo_s;
  logic signed [R4_HI_W-1:0]  r4_hi_s;
  logic signed [R6_LO_W:0]    r6_lo_s;
  logic signed [R6_HI_W-1:0]  r6_hi_s;
  logic signed [FAC_LO_W:0]   fac_lo_s;
  logic signed [FAC_HI_W-1:0] fac_hi_s;
  logic signed [OX_W-1:0]     ox, oy;

  assign r4_lo_s  = $signed({1'b0, r4_q[R4_LO_W-1:0]});
  assign r4_hi_s  = r4_q[R4_W-1:R4_LO_W];
  assign r6_lo_s  = $signed({1'b0, r6_q[R6_LO_W-1:0]});
  assign r6_hi_s  = r6_q[R6_W-1:R6_LO_W];
  assign fac_lo_s = $signed({1'b0, fac_q[FAC_LO_W-1:0]});
  assign fac_hi_s = fac_q[FAC_W-1:FAC_LO_W];

  // Datapath, one block per stage
  always_comb begin
    // s1: squares and cross term
    xx_d = SQ_W'(rnd_c(mul_t'(point_x_i) * mul_t'(point_x_i)));
    yy_d = SQ_W'(rnd_c(mul_t'(point_y_i) * mul_t'(point_y_i)));
    xy_d = SQ_W'(rnd_c(mul_t'(point_x_i) * mul_t'(point_y_i)));

    // s2: r2 and the tangential operands
    r2_d  = R2_W'(xx_q) + R2_W'(yy_q);
    xy2_d = R2_W'(xy_q) <<< 1;
    sx_d  = TS_W'(xx_q) + TS_W'(yy_q) + (TS_W'(xx_q) <<< 1);
    sy_d  = TS_W'(xx_q) + TS_W'(yy_q) + (TS_W'(yy_q) <<< 1);

    // s3: r4, k1 term, tangential products
    r4_d  = R4_W'(rnd_c(mul_t'(r2_q) * mul_t'(r2_q)));
    kr2_d = KR2_W'(rnd_k(mul_t'(k1_q) * mul_t'(r2_q)));
    ta_d  = KR2_W'(rnd_k(mul_t'(p1_q) * mul_t'(xy2_q)));
    tb_d  = KT_W'(rnd_k(mul_t'(p2_q) * mul_t'(sx_q)));
    tc_d  = KR2_W'(rnd_k(mul_t'(p2_q) * mul_t'(xy2_q)));
    td_d  = KT_W'(rnd_k(mul_t'(p1_q) * mul_t'(sy_q)));

    // s4: split products on r4, start the radial factor, tangential sums
    r6lo_d = R6P_LO_W'(mul_t'(r4_lo_s) * mul_t'(r2b_q));
    r6hi_d = R6P_HI_W'(mul_t'(r4_hi_s) * mul_t'(r2b_q));
    k4lo_d = K4P_LO_W'(mul_t'(r4_lo_s) * mul_t'(k2_q));
    k4hi_d = K4P_HI_W'(mul_t'(r4_hi_s) * mul_t'(k2_q));
    fac1_d = FAC_ONE + FAC_W'(kr2_q);
    tx_d   = TX_W'(ta_q) + TX_W'(tb_q);
    ty_d   = TX_W'(tc_q) + TX_W'(td_q);

    // s5: merge and round r6 and k2*r4
    r6_d  = R6_W'(rnd_c((mul_t'(r6hi_q) <<< R4_LO_W) + mul_t'(r6lo_q)));
    kr4_d = KR4_W'(rnd_k((mul_t'(k4hi_q) <<< R4_LO_W) + mul_t'(k4lo_q)));

    // s6: split k3*r6, add k2 term
    k6lo_d = K6P_LO_W'(mul_t'(r6_lo_s) * mul_t'(k3_q));
    k6hi_d = K6P_HI_W'(mul_t'(r6_hi_s) * mul_t'(k3_q));
    fac2_d = fac1b_q + FAC_W'(kr4_q);

    // s7: merge and round k3*r6
    kr6_d = KR6_W'(rnd_k((mul_t'(k6hi_q) <<< R6_LO_W) + mul_t'(k6lo_q)));

    // s8: final radial factor
    fac_d = fac2b_q + FAC_W'(kr6_q);

    // s9: split coordinate times factor
    mxlo_d = XFP_LO_W'(mul_t'(xp_q[8]) * mul_t'(fac_lo_s));
    mxhi_d = XFP_HI_W'(mul_t'(xp_q[8]) * mul_t'(fac_hi_s));
    mylo_d = XFP_LO_W'(mul_t'(yp_q[8]) * mul_t'(fac_lo_s));
    myhi_d = XFP_HI_W'(mul_t'(yp_q[8]) * mul_t'(fac_hi_s));

    // s10: merge and round
    mx_d = MX_W'(rnd_c((mul_t'(mxhi_q) <<< FAC_LO_W) + mul_t'(mxlo_q)));
    my_d = MX_W'(rnd_c((mul_t'(myhi_q) <<< FAC_LO_W) + mul_t'(mylo_q)));

    // s11: add tangential part, clamp, bypass when disabled
    ox    = OX_W'(mx_q) + OX_W'(tx_q[10]);
    oy    = OX_W'(my_q) + OX_W'(ty_q[10]);
    sat_d = 1'b0;
    if (ox > OUT_MAX) begin
      out_x_d = COORD_WIDTH'(OUT_MAX);
      sat_d   = 1'b1;
    end else if (ox < OUT_MIN) begin
      out_x_d = COORD_WIDTH'(OUT_MIN);
      sat_d   = 1'b1;
    end else begin
      out_x_d = COORD_WIDTH'(ox);
    end
    if (oy > OUT_MAX) begin
      out_y_d = COORD_WIDTH'(OUT_MAX);
      sat_d   = 1'b1;
    end else if (oy < OUT_MIN) begin
      out_y_d = COORD_WIDTH'(OUT_MIN);
      sat_d   = 1'b1;
    end else begin
      out_y_d = COORD_WIDTH'(oy);
    end
    if (!enable_q) begin
      out_x_d = xp_q[10];
      out_y_d = yp_q[10];
      sat_d   = 1'b0;
    end
  end

  // Payload registers: the pipeline never stalls, so they load every cycle
  always_ff @(posedge clk_i) begin
    xp_q[1] <= point_x_i;
    yp_q[1] <= point_y_i;
    for (int i = 2; i <= 10; i++) begin
      xp_q[i] <= xp_q[i-1];
      yp_q[i] <= yp_q[i-1];
    end
    tx_q[4] <= tx_d;
    ty_q[4] <= ty_d;
    for (int i = 5; i <= 10; i++) begin
      tx_q[i] <= tx_q[i-1];
      ty_q[i] <= ty_q[i-1];
    end
    xx_q    <= xx_d;
    yy_q    <= yy_d;
    xy_q    <= xy_d;
    r2_q    <= r2_d;
    xy2_q   <= xy2_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    r2b_q   <= r2_q;
    r4_q    <= r4_d;
    kr2_q   <= kr2_d;
    ta_q    <= ta_d;
    tb_q    <= tb_d;
    tc_q    <= tc_d;
    td_q    <= td_d;
    r6lo_q  <= r6lo_d;
    r6hi_q  <= r6hi_d;
    k4lo_q  <= k4lo_d;
    k4hi_q  <= k4hi_d;
    fac1_q  <= fac1_d;
    r6_q    <= r6_d;
    kr4_q   <= kr4_d;
    fac1b_q <= fac1_q;
    k6lo_q  <= k6lo_d;
    k6hi_q  <= k6hi_d;
    fac2_q  <= fac2_d;
    kr6_q   <= kr6_d;
    fac2b_q <= fac2_q;
    fac_q   <= fac_d;
    mxlo_q  <= mxlo_d;
    mxhi_q  <= mxhi_d;
    mylo_q  <= mylo_d;
    myhi_q  <= myhi_d;
    mx_q    <= mx_d;
    my_q    <= my_d;
    out_x_q <= out_x_d;
    out_y_q <= out_y_d;
    sat_q   <= sat_d;
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= LAT; i++) begin
        v_q[i] <= 1'b0;
      end
    end else begin
      v_q[1] <= start_i && !busy_o;
      for (int i = 2; i <= LAT; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  // Configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      k1_q     <= '0;
      k2_q     <= '0;
      k3_q     <= '0;
      p1_q     <= '0;
      p2_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ENABLE: enable_q <= cfg_data_i[0];
        REG_K1:     k1_q     <= cfg_data_i;
        REG_K2:     k2_q     <= cfg_data_i;
        REG_K3:     k3_q     <= cfg_data_i;
        REG_P1:     p1_q     <= cfg_data_i;
        REG_P2:     p2_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Ports
  assign busy_o         = 1'b0;
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = v_q[LAT];
  assign out_x_o        = out_x_q;
  assign out_y_o        = out_y_q;
  assign saturated_o    = sat_q;

  // Each accepted point yields exactly one result at the end of the pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, LAT) |-> (result_valid_o == $past(start_i && !busy_o, LAT)))
    else $error("result strobe does not match accepted point");

  // Bypass never flags saturation
  a_bypass_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !$past(enable_q)) |-> !saturated_o)
    else $error("saturation flagged with correction disabled");

  // Bypass returns the point unchanged
  a_bypass_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !$past(enable_q) && $past(rst_ni, LAT)) |->
      (out_x_o == $past(point_x_i, LAT) && out_y_o == $past(point_y_i, LAT)))
    else $error("bypass point altered");

  // A flagged result sits at a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && saturated_o) |->
      (out_x_o == COORD_WIDTH'(OUT_MAX) || out_x_o == COORD_WIDTH'(OUT_MIN) ||
       out_y_o == COORD_WIDTH'(OUT_MAX) || out_y_o == COORD_WIDTH'(OUT_MIN)))
    else $error("saturated result not at a range limit");

endmodule

`default_nettype wire

[tb/lens_distortion_apply_top_tb.sv]
// Self-checking bench for lens_distortion_apply_top: directed points, then random phases
// with fresh coefficient words, each result checked against a typed expectation or a fixed-point predictor.
// Depends on lda_pkg and lens_distortion_apply_top.
`default_nettype none

module lens_distortion_apply_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lda_pkg::*;

  localparam int LATENCY = 11;
  localparam int LIMIT   = 400000;
  localparam int NPROBES = 22;

  localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COEFF_WIDTH-1:0] KMAX = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
  localparam logic signed [COEFF_WIDTH-1:0] KMIN = {1'b1, {(COEFF_WIDTH-1){1'b0}}};
  localparam longint ILIM = 64'sh3FFF_FFFF_FFFF_FFFF;

  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ox;
    logic signed [COORD_WIDTH-1:0] oy;
    logic                          sat;
  } warped_pt_t;

  typedef struct {
    logic                          en;
    logic signed [COEFF_WIDTH-1:0] k1, k2, k3, p1, p2;
  } lens_cfg_t;

  typedef struct {
    int                            setting;
    logic signed [COORD_WIDTH-1:0] x, y;
    logic                          known;
    warped_pt_t                    typed;
  } probe_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic signed [COORD_WIDTH-1:0] point_x_i;
  logic signed [COORD_WIDTH-1:0] point_y_i;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [CFG_IDX_W-1:0]          cfg_index_i;
  logic [COEFF_WIDTH-1:0]        cfg_data_i;
  logic                          result_valid_o;
  logic signed [COORD_WIDTH-1:0] out_x_o;
  logic signed [COORD_WIDTH-1:0] out_y_o;
  logic                          saturated_o;

  // sideband that travels with each point word: typed expectation, if any
  logic       row_known;
  warped_pt_t row_expect;

  // predictor copy of the register file
  logic   lens_en;
  longint coef_k1, coef_k2, coef_k3, coef_p1, coef_p2;

  warped_pt_t awaited_warps[$];
  int         errors;
  int         cycles;

  lens_distortion_apply_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .saturated_o    (saturated_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  function automatic longint clip62(logic signed [127:0] v);
    if (v > ILIM) return ILIM;
    if (v < -ILIM) return -ILIM;
    return longint'(v[63:0]);
  endfunction

  function automatic longint sum_sat(longint a, longint b);
    logic signed [127:0] s;
    s = a;
    s = s + b;
    return clip62(s);
  endfunction

  // a*b / 2^sh, nearest with ties away from zero, then clipped
  function automatic longint mul_round(longint a, longint b, int sh);
    logic signed [127:0] wa, wb, p;
    logic [127:0]        mag;
    logic                neg;
    wa  = a;
    wb  = b;
    p   = wa * wb;
    neg = p[127];
    mag = neg ? -p : p;
    mag = (mag + (128'd1 << (sh - 1))) >> sh;
    if (mag > 128'h3FFF_FFFF_FFFF_FFFF) mag = 128'h3FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] fit_coord(longint v, inout logic sat);
    longint hi, lo;
    hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return CMAX;
    end
    if (v < lo) begin
      sat = 1'b1;
      return CMIN;
    end
    return v[COORD_WIDTH-1:0];
  endfunction

  function automatic warped_pt_t distort_point(logic signed [COORD_WIDTH-1:0] px,
                                               logic signed [COORD_WIDTH-1:0] py);
    longint     x, y, xx, yy, xy, r2, r4, r6, fac, xy2, tx, ty;
    warped_pt_t w;
    logic       sat;
    w.ox  = px;
    w.oy  = py;
    w.sat = 1'b0;
    if (!lens_en) return w;
    x   = px;
    y   = py;
    xx  = mul_round(x, x, FRAC_C);
    yy  = mul_round(y, y, FRAC_C);
    xy  = mul_round(x, y, FRAC_C);
    r2  = sum_sat(xx, yy);
    r4  = mul_round(r2, r2, FRAC_C);
    r6  = mul_round(r4, r2, FRAC_C);
    xy2 = sum_sat(xy, xy);
    // radial factor, summed left to right
    fac = longint'(1) <<< FRAC_C;
    fac = sum_sat(fac, mul_round(coef_k1, r2, FRAC_K));
    fac = sum_sat(fac, mul_round(coef_k2, r4, FRAC_K));
    fac = sum_sat(fac, mul_round(coef_k3, r6, FRAC_K));
    // tangential terms
    tx  = sum_sat(mul_round(coef_p1, xy2, FRAC_K),
                  mul_round(coef_p2, sum_sat(sum_sat(r2, xx), xx), FRAC_K));
    ty  = sum_sat(mul_round(coef_p2, xy2, FRAC_K),
                  mul_round(coef_p1, sum_sat(sum_sat(r2, yy), yy), FRAC_K));
    sat  = 1'b0;
    w.ox = fit_coord(sum_sat(mul_round(x, fac, FRAC_C), tx), sat);
    w.oy = fit_coord(sum_sat(mul_round(y, fac, FRAC_C), ty), sat);
    w.sat = sat;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: register writes, point words taken, results checked in order
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : watch
    warped_pt_t want;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ENABLE: lens_en = cfg_data_i[0];
        REG_K1:     coef_k1 = $signed(cfg_data_i);
        REG_K2:     coef_k2 = $signed(cfg_data_i);
        REG_K3:     coef_k3 = $signed(cfg_data_i);
        REG_P1:     coef_p1 = $signed(cfg_data_i);
        REG_P2:     coef_p2 = $signed(cfg_data_i);
        default:    ;
      endcase
    end
    if (start_i && !busy_o) begin
      awaited_warps.insert(awaited_warps.size(),
                           row_known ? row_expect : distort_point(point_x_i, point_y_i));
    end
    if (result_valid_o) begin
      if (awaited_warps.size() == 0) begin
        $error("result word with nothing expected: out_x %0d out_y %0d saturated %0b",
               out_x_o, out_y_o, saturated_o);
        errors++;
      end else begin
        want = awaited_warps.pop_front();
        if (out_x_o !== want.ox) begin
          $error("out_x: expected %0d, got %0d", want.ox, out_x_o);
          errors++;
        end
        if (out_y_o !== want.oy) begin
          $error("out_y: expected %0d, got %0d", want.oy, out_y_o);
          errors++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  // run-away guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver helpers
  // ---------------------------------------------------------------------------

  // Leaves start_i high so the next point can follow back to back
  task automatic drive_point(logic signed [COORD_WIDTH-1:0] px,
                             logic signed [COORD_WIDTH-1:0] py,
                             logic known, warped_pt_t typed, int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    point_x_i  <= px;
    point_y_i  <= py;
    row_known  <= known;
    row_expect <= typed;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Stop sending and wait until the pipeline has drained
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_warps.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after the last word
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEFF_WIDTH-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_setting(lens_cfg_t s);
    write_reg(REG_ENABLE, {(COEFF_WIDTH-1)'($urandom()), s.en});
    write_reg(REG_K1, s.k1);
    write_reg(REG_K2, s.k2);
    write_reg(REG_K3, s.k3);
    write_reg(REG_P1, s.p1);
    write_reg(REG_P2, s.p2);
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int idle_burst(logic allow);
    return (allow && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
  endfunction

  // mostly points inside +-1.5, some anywhere, some at the edges
  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 4))
        0:       return CMAX;
        1:       return CMIN;
        2:       return '0;
        3:       return 1;
        default: return -1;
      endcase
    end
    if (pick <= 2) return COORD_WIDTH'($urandom());
    return COORD_WIDTH'($signed($urandom_range(0, 3145728)) - 1572864);
  endfunction

  // mostly lens-like coefficients within +-0.5, some raw words and extremes
  function automatic logic signed [COEFF_WIDTH-1:0] rand_coeff();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 2))
        0:       return KMAX;
        1:       return KMIN;
        default: return '0;
      endcase
    end
    if (pick <= 2) return $urandom();
    return $signed($urandom_range(0, 16777216)) - 8388608;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    probe_t    probes[NPROBES];
    lens_cfg_t settings[7];
    lens_cfg_t s;
    int        cur_setting;
    logic      idle_on;

    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    point_x_i   <= '0;
    point_y_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_ENABLE;
    cfg_data_i  <= '0;
    row_known   <= 1'b0;
    row_expect  <= '0;
    lens_en     = 1'b0;
    coef_k1     = 0;
    coef_k2     = 0;
    coef_k3     = 0;
    coef_p1     = 0;
    coef_p2     = 0;
    errors      = 0;
    cycles      = 0;

    // register settings for the directed part; 0 matches the reset state
    settings[0] = '{1'b0, 0, 0, 0, 0, 0};
    settings[1] = '{1'b1, 0, 0, 0, 0, 0};
    settings[2] = '{1'b1, KMAX, 0, 0, 0, 0};
    settings[3] = '{1'b1, KMIN, KMIN, KMIN, KMIN, KMIN};
    settings[4] = '{1'b1, KMAX, KMAX, KMAX, KMAX, KMAX};
    settings[5] = '{1'b1, -4697620, 1174405, 0, 16777, -8389};
    settings[6] = '{1'b0, KMAX, KMAX, KMAX, KMAX, KMAX};

    // after reset: pass-through
    probes[0]  = '{0, CMAX, CMAX, 1'b1, '{CMAX, CMAX, 1'b0}};
    probes[1]  = '{0, CMIN, CMIN, 1'b1, '{CMIN, CMIN, 1'b0}};
    probes[2]  = '{0, 0, 0, 1'b1, '{0, 0, 1'b0}};
    // enabled, all coefficients zero: unit factor, no tangential part
    probes[3]  = '{1, CMAX, CMIN, 1'b1, '{CMAX, CMIN, 1'b0}};
    probes[4]  = '{1, 1, -1, 1'b1, '{1, -1, 1'b0}};
    probes[5]  = '{1, CMIN, CMAX, 1'b1, '{CMIN, CMAX, 1'b0}};
    // largest k1: corners clamp, the center stays put
    probes[6]  = '{2, CMAX, CMAX, 1'b1, '{CMAX, CMAX, 1'b1}};
    probes[7]  = '{2, CMIN, CMIN, 1'b1, '{CMIN, CMIN, 1'b1}};
    probes[8]  = '{2, CMAX, CMIN, 1'b1, '{CMAX, CMIN, 1'b1}};
    probes[9]  = '{2, 0, 0, 1'b1, '{0, 0, 1'b0}};
    // all coefficients at the negative extreme
    probes[10] = '{3, CMAX, CMAX, 1'b0, '0};
    probes[11] = '{3, CMIN, CMAX, 1'b0, '0};
    probes[12] = '{3, 0, CMIN, 1'b0, '0};
    probes[13] = '{3, COORD_WIDTH'(1 << FRAC_C), 0, 1'b0, '0};
    // all coefficients at the positive extreme
    probes[14] = '{4, CMAX, CMIN, 1'b0, '0};
    probes[15] = '{4, 1, 1, 1'b0, '0};
    probes[16] = '{4, -1, -1, 1'b0, '0};
    // a typical barrel lens
    probes[17] = '{5, 524288, 524288, 1'b0, '0};
    probes[18] = '{5, -3145728, 2097152, 1'b0, '0};
    probes[19] = '{5, 1, 0, 1'b0, '0};
    // disabled with coefficients loaded: still pass-through
    probes[20] = '{6, CMAX, CMAX, 1'b1, '{CMAX, CMAX, 1'b0}};
    probes[21] = '{6, 12345, -54321, 1'b1, '{12345, -54321, 1'b0}};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    cur_setting = 0;
    foreach (probes[i]) begin
      if (probes[i].setting != cur_setting) begin
        settle();
        load_setting(settings[probes[i].setting]);
        cur_setting = probes[i].setting;
      end
      drive_point(probes[i].x, probes[i].y, probes[i].known, probes[i].typed,
                  idle_burst(1'b1));
    end

    // random phases: new coefficients each phase, no idling in the third and the last one
    for (int ph = 0; ph < 6; ph++) begin
      s.en = (ph == 0) || ($urandom_range(0, 4) != 0);
      s.k1 = rand_coeff();
      s.k2 = rand_coeff();
      s.k3 = rand_coeff();
      s.p1 = rand_coeff();
      s.p2 = rand_coeff();
      settle();
      load_setting(s);
      idle_on = (ph != 2) && (ph != 5);
      for (int n = 0; n < 100; n++) begin
        if (ph == 1 && n == 50) settle();
        drive_point(rand_coord(), rand_coord(), 1'b0, '0, idle_burst(idle_on));
      end
    end

    // drain and report
    start_i <= 1'b0;
    while (awaited_warps.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/lda_pkg.sv
rtl/core/lens_distortion_apply_top.sv
tb/lens_distortion_apply_top_tb.sv
